FILE: sv/cholesky_whitened_chi_square_unit_assert.svh
// Assertion macros used by the top-level RTL file.
// Every assertion samples on the rising edge of clk and is ignored while rst_n is low.
`ifndef CHOLESKY_WHITENED_CHI_SQUARE_UNIT_ASSERT_SVH
`define CHOLESKY_WHITENED_CHI_SQUARE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CWCS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define CWCS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CWCS_ASSERT_NEVER(lbl, cond, msg)
`define CWCS_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/cwcs_pkg.sv
package cwcs_pkg;

  localparam int MAX_RESIDUALS_DEF = 64;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int CNT_W = 7;
  localparam int ROW_W = 6;
  localparam int VAL_W = 32;
  localparam int WR_W  = 48;
  localparam int CHI_W = 64;

  localparam logic [CNT_W-1:0] RC_RESET = 7'd64;

  // Register select is paddr bit 2 (registers on 4-byte spacing).
  localparam logic REG_RESIDUAL_COUNT = 1'b0;

  localparam int CQ_DEPTH = 4;
  localparam int OQ_DEPTH = 4;

  localparam logic [WR_W-1:0] W48_MAX = {1'b0, {(WR_W-1){1'b1}}};
  localparam logic [WR_W-1:0] W48_MIN = {1'b1, {(WR_W-1){1'b0}}};

  typedef enum logic {
    KIND_RESIDUAL = 1'b0,
    KIND_ENTRY    = 1'b1
  } cwcs_kind_t;

  // One matrix entry on its way from front to back.
  typedef struct packed {
    logic [VAL_W-1:0] entry;
    logic [VAL_W-1:0] resid;
    logic [ROW_W-1:0] row;
    logic             row_end;
    logic             row_last;
  } cwcs_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [WR_W-1:0]  whitened_residual;
    logic [CHI_W-1:0] chi_square;
    logic             last;
  } cwcs_res_t;

endpackage

FILE: sv/cholesky_whitened_chi_square_unit.sv
// Whitened residuals and chi-square through a lower-triangular factor.
// Input queue port (push/full, in_kind, in_value): first residual_count residuals
// (kind 0), then the factor's lower triangle row by row, column 0 up to the diagonal
// (kind 1). Early entries and surplus residuals are dropped.
// Result queue port (empty/pop): one item per row at its diagonal entry, with the row
// index, the 48-bit saturated whitened residual, the running Q32.32 chi-square and
// a last flag on the final row; the block then goes back to loading residuals.
// APB port: residual_count at address 0, reset value 64, clamped to [2, MAX_RESIDUALS].
// Throughput: one item per cycle while full is low. Full rises only when the 4-entry
// command queue between front and back is spoken for.
// A diagonal entry reaches the result queue through store read, command queue,
// multiply, accumulate, clamp, square, then chi sum.
// A stalled receiver backs up the 4-entry result queue; row ends then wait in the
// command queue, that queue fills and full goes high. Nothing is dropped.
// Reset empties both queues and clears the counters and sums. The residual store is
// not cleared; only entries loaded in the current pass are ever read.
`include "cholesky_whitened_chi_square_unit_assert.svh"
module cholesky_whitened_chi_square_unit #(
  parameter int MAX_RESIDUALS = cwcs_pkg::MAX_RESIDUALS_DEF,
  parameter int FRAC_BITS     = cwcs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input item queue
  input  logic                              push,
  output logic                              full,
  input  logic                              in_kind,
  input  logic signed [cwcs_pkg::VAL_W-1:0] in_value,
  // result queue
  output logic                              empty,
  input  logic                              pop,
  output logic [cwcs_pkg::ROW_W-1:0]        out_row_index,
  output logic signed [cwcs_pkg::WR_W-1:0]  out_whitened_residual,
  output logic [cwcs_pkg::CHI_W-1:0]        out_chi_square,
  output logic                              out_last,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import cwcs_pkg::*;

  logic [CNT_W-1:0] rc_r;
  logic             cfg_wr, cfg_hit;

  logic             cmd_push, cmd_pop, cq_full, cq_empty;
  cwcs_cmd_t        cmd_data, cq_head;
  logic             oq_push, oq_pop, oq_full;
  cwcs_res_t        oq_item, oq_head;

  // ---- configuration register ----
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_RESIDUAL_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? 32'(rc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= RC_RESET;
    end else if (cfg_wr) begin
      rc_r <= pwdata[CNT_W-1:0];
    end
  end

  // ---- front: accept, classify, residual store, sequencing ----
  cwcs_front #(
    .MAX_RESIDUALS (MAX_RESIDUALS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .residual_count (rc_r),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .cmd_pop        (cmd_pop),
    .cmd_push       (cmd_push),
    .cmd_data       (cmd_data)
  );

  // ---- command queue between front and back ----
  cwcs_fifo #(
    .W     ($bits(cwcs_cmd_t)),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_data),
    .rd_en   (cmd_pop),
    .rd_data (cq_head),
    .full    (cq_full),
    .empty   (cq_empty)
  );

  // ---- back: multiply-accumulate, saturate, chi-square ----
  cwcs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_head  (cq_head),
    .cq_pop   (cmd_pop),
    .oq_pop   (oq_pop),
    .oq_push  (oq_push),
    .oq_item  (oq_item)
  );

  // ---- result queue ----
  assign oq_pop = pop && !empty;

  cwcs_fifo #(
    .W     ($bits(cwcs_res_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (oq_item),
    .rd_en   (oq_pop),
    .rd_data (oq_head),
    .full    (oq_full),
    .empty   (empty)
  );

  assign out_row_index         = oq_head.row_index;
  assign out_whitened_residual = oq_head.whitened_residual;
  assign out_chi_square        = oq_head.chi_square;
  assign out_last              = oq_head.last;

  // ---- checks ----
  `CWCS_ASSERT_NEVER(a_cmd_q_overflow, cmd_push && cq_full, "command queue written while full")
  `CWCS_ASSERT_NEVER(a_out_q_overflow, oq_push && oq_full, "result queue written while full")
  `CWCS_ASSERT_IMPLY(a_last_on_diag, cmd_push && cmd_data.row_last && !cmd_data.row_end, 1'b0, "final row flagged off diagonal")

endmodule

FILE: sv/cwcs_ram.sv
module cwcs_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/cwcs_fifo.sv
module cwcs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: sv/cwcs_front.sv
module cwcs_front #(
  parameter int MAX_RESIDUALS = cwcs_pkg::MAX_RESIDUALS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cwcs_pkg::CNT_W-1:0]        residual_count,
  input  logic                              push,
  output logic                              full,
  input  logic                              in_kind,
  input  logic signed [cwcs_pkg::VAL_W-1:0] in_value,
  input  logic                              cmd_pop,
  output logic                              cmd_push,
  output cwcs_pkg::cwcs_cmd_t               cmd_data
);
  import cwcs_pkg::*;

  localparam int RW  = (MAX_RESIDUALS > 1) ? $clog2(MAX_RESIDUALS) : 1;
  localparam int LCW = $clog2(MAX_RESIDUALS + 1);
  localparam int CW  = (LCW > CNT_W) ? LCW : CNT_W;
  localparam int QCW = $clog2(CQ_DEPTH + 1);

  logic [LCW-1:0]   load_cnt_r, load_cnt_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [RW-1:0]    col_r, col_nxt;
  logic [QCW-1:0]   cq_used_r, cq_used_nxt;
  logic             s1_valid_r;
  logic [VAL_W-1:0] s1_entry_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_end_r;
  logic             s1_last_r;

  logic [CW-1:0]    rc_w;
  logic [LCW-1:0]   n_eff;
  logic [LCW-1:0]   row_p1;
  logic             accept, is_entry, loaded, res_wr, mat_go, row_end, row_last;
  logic [VAL_W-1:0] resid_q;

  // effective dimension: count clamped to [2, MAX_RESIDUALS]
  always_comb begin
    rc_w = CW'(residual_count);
    if (rc_w < CW'(2)) begin
      n_eff = LCW'(2);
    end else if (rc_w > CW'(MAX_RESIDUALS)) begin
      n_eff = LCW'(MAX_RESIDUALS);
    end else begin
      n_eff = LCW'(rc_w);
    end
  end

  assign full     = (cq_used_r == QCW'(CQ_DEPTH));
  assign accept   = push && !full;
  assign is_entry = (cwcs_kind_t'(in_kind) == KIND_ENTRY);
  assign loaded   = (load_cnt_r >= n_eff);
  assign res_wr   = accept && !is_entry && !loaded;
  assign mat_go   = accept && is_entry && loaded;
  assign row_end  = !(col_r < row_r);
  assign row_p1   = LCW'(row_r) + LCW'(1);
  assign row_last = (row_p1 >= n_eff);

  cwcs_ram #(
    .W     (VAL_W),
    .DEPTH (MAX_RESIDUALS)
  ) u_store (
    .clk   (clk),
    .we    (res_wr),
    .waddr (load_cnt_r[RW-1:0]),
    .wdata (in_value),
    .re    (mat_go),
    .raddr (col_r),
    .rdata (resid_q)
  );

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    if (res_wr) begin
      load_cnt_nxt = load_cnt_r + LCW'(1);
    end
    if (mat_go) begin
      if (row_end) begin
        col_nxt = '0;
        if (row_last) begin
          load_cnt_nxt = '0;
          row_nxt      = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + RW'(1);
      end
    end
    // slots held by the s1 stage and the command queue
    cq_used_nxt = cq_used_r + QCW'(mat_go) - QCW'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      cq_used_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      cq_used_r  <= cq_used_nxt;
      s1_valid_r <= mat_go;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_go) begin
      s1_entry_r <= in_value;
      s1_row_r   <= ROW_W'(row_r);
      s1_end_r   <= row_end;
      // final-row flag rides only on the diagonal entry
      s1_last_r  <= row_end && row_last;
    end
  end

  assign cmd_push          = s1_valid_r;
  assign cmd_data.entry    = s1_entry_r;
  assign cmd_data.resid    = resid_q;
  assign cmd_data.row      = s1_row_r;
  assign cmd_data.row_end  = s1_end_r;
  assign cmd_data.row_last = s1_last_r;

endmodule

FILE: sv/cwcs_back.sv
module cwcs_back #(
  parameter int FRAC_BITS = cwcs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cq_empty,
  input  cwcs_pkg::cwcs_cmd_t cq_head,
  output logic                cq_pop,
  input  logic                oq_pop,
  output logic                oq_push,
  output cwcs_pkg::cwcs_res_t oq_item
);
  import cwcs_pkg::*;

  localparam int OUW = $clog2(OQ_DEPTH + 1);

  logic [OUW-1:0]     out_used_r, out_used_nxt;

  logic               a_valid_r;
  logic signed [63:0] a_prod_r;
  logic               a_end_r, a_last_r;
  logic [ROW_W-1:0]   a_row_r;

  logic signed [63:0] row_sum_r;
  logic               b_valid_r;
  logic [63:0]        b_sum_r;
  logic               b_last_r;
  logic [ROW_W-1:0]   b_row_r;

  logic               c_valid_r;
  logic [WR_W-1:0]    c_w_r, c_mag_r;
  logic               c_last_r;
  logic [ROW_W-1:0]   c_row_r;

  logic               d_valid_r;
  logic [CHI_W-1:0]   d_sq_r;
  logic [WR_W-1:0]    d_w_r;
  logic               d_last_r;
  logic [ROW_W-1:0]   d_row_r;

  logic [CHI_W-1:0]   square_sum_r;

  logic signed [31:0] op_e, op_r;
  logic signed [63:0] prod_c, shifted, sum_raw, sum_sat;
  logic               ovf_pos, ovf_neg;
  logic [WR_W-1:0]    w_c, mag_c;
  logic [CHI_W-1:0]   sq_c;
  logic [CHI_W:0]     chi_raw;
  logic [CHI_W-1:0]   chi_c;

  // row ends need a reserved result slot before they leave the queue
  assign cq_pop = !cq_empty && (!cq_head.row_end || (out_used_r < OUW'(OQ_DEPTH)));
  assign out_used_nxt = out_used_r + OUW'(cq_pop && cq_head.row_end) - OUW'(oq_pop);

  // stage A: product
  assign op_e   = $signed(cq_head.entry);
  assign op_r   = $signed(cq_head.resid);
  assign prod_c = op_e * op_r;

  // stage B: floor shift and saturating accumulate
  assign shifted = a_prod_r >>> FRAC_BITS;
  assign sum_raw = row_sum_r + shifted;
  assign ovf_pos = !row_sum_r[63] && !shifted[63] && sum_raw[63];
  assign ovf_neg = row_sum_r[63] && shifted[63] && !sum_raw[63];
  always_comb begin
    if (ovf_pos) begin
      sum_sat = {1'b0, {63{1'b1}}};
    end else if (ovf_neg) begin
      sum_sat = {1'b1, {63{1'b0}}};
    end else begin
      sum_sat = sum_raw;
    end
  end

  // stage C: clamp to 48 bits, magnitude
  always_comb begin
    if ((&b_sum_r[63:WR_W-1]) || !(|b_sum_r[63:WR_W-1])) begin
      w_c = b_sum_r[WR_W-1:0];
    end else if (b_sum_r[63]) begin
      w_c = W48_MIN;
    end else begin
      w_c = W48_MAX;
    end
    mag_c = w_c[WR_W-1] ? (WR_W'(0) - w_c) : w_c;
  end

  // stage D: square, saturated once magnitude reaches 2^32
  assign sq_c = (|c_mag_r[WR_W-1:32]) ? '1 : (c_mag_r[31:0] * c_mag_r[31:0]);

  // stage E: saturating chi-square accumulate straight into the result queue
  assign chi_raw = {1'b0, square_sum_r} + {1'b0, d_sq_r};
  assign chi_c   = chi_raw[CHI_W] ? '1 : chi_raw[CHI_W-1:0];

  assign oq_push                   = d_valid_r;
  assign oq_item.row_index         = d_row_r;
  assign oq_item.whitened_residual = d_w_r;
  assign oq_item.chi_square        = chi_c;
  assign oq_item.last              = d_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_used_r   <= '0;
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
      c_valid_r    <= 1'b0;
      d_valid_r    <= 1'b0;
      row_sum_r    <= '0;
      square_sum_r <= '0;
    end else begin
      out_used_r <= out_used_nxt;
      a_valid_r  <= cq_pop;
      b_valid_r  <= a_valid_r && a_end_r;
      c_valid_r  <= b_valid_r;
      d_valid_r  <= c_valid_r;
      if (a_valid_r) begin
        row_sum_r <= a_end_r ? '0 : sum_sat;
      end
      if (d_valid_r) begin
        square_sum_r <= d_last_r ? '0 : chi_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      a_prod_r <= prod_c;
      a_end_r  <= cq_head.row_end;
      a_last_r <= cq_head.row_last;
      a_row_r  <= cq_head.row;
    end
    if (a_valid_r && a_end_r) begin
      b_sum_r  <= sum_sat;
      b_last_r <= a_last_r;
      b_row_r  <= a_row_r;
    end
    if (b_valid_r) begin
      c_w_r    <= w_c;
      c_mag_r  <= mag_c;
      c_last_r <= b_last_r;
      c_row_r  <= b_row_r;
    end
    if (c_valid_r) begin
      d_sq_r   <= sq_c;
      d_w_r    <= c_w_r;
      d_last_r <= c_last_r;
      d_row_r  <= c_row_r;
    end
  end

endmodule
